FILE: hdl/rvid_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rvid_pkg
// Shared types and constants for the RV32I instruction decoder.
// ----------------------------------------------------------------------------
package rvid_pkg;

   localparam int unsigned InstrWidth = 32;
   localparam int unsigned IdWidth    = 6;
   localparam int unsigned RegWidth   = 5;
   localparam int unsigned CsrWidth   = 12;
   localparam int unsigned FenceWidth = 4;
   localparam int unsigned RspPad     = 7;

   localparam logic [6:0] OPC_OP      = 7'h33;
   localparam logic [6:0] OPC_LOAD    = 7'h03;
   localparam logic [6:0] OPC_OPIMM   = 7'h13;
   localparam logic [6:0] OPC_STORE   = 7'h23;
   localparam logic [6:0] OPC_BRANCH  = 7'h63;
   localparam logic [6:0] OPC_AUIPC   = 7'h17;
   localparam logic [6:0] OPC_LUI     = 7'h37;
   localparam logic [6:0] OPC_JAL     = 7'h6F;
   localparam logic [6:0] OPC_JALR    = 7'h67;
   localparam logic [6:0] OPC_SYSTEM  = 7'h73;
   localparam logic [6:0] OPC_MISCMEM = 7'h0F;

   localparam logic [6:0]  FUNCT7_ALT   = 7'h20;
   localparam logic [6:0]  FUNCT7_ZERO  = 7'h00;
   localparam logic [11:0] SYS_ECALL    = 12'h000;
   localparam logic [11:0] SYS_EBREAK   = 12'h001;

   typedef enum logic [IdWidth-1:0] {
      MN_LUI     = 6'd0,
      MN_AUIPC   = 6'd1,
      MN_JAL     = 6'd2,
      MN_JALR    = 6'd3,
      MN_BEQ     = 6'd4,
      MN_BNE     = 6'd5,
      MN_BLT     = 6'd6,
      MN_BGE     = 6'd7,
      MN_BLTU    = 6'd8,
      MN_BGEU    = 6'd9,
      MN_LB      = 6'd10,
      MN_LH      = 6'd11,
      MN_LW      = 6'd12,
      MN_LBU     = 6'd13,
      MN_LHU     = 6'd14,
      MN_SB      = 6'd15,
      MN_SH      = 6'd16,
      MN_SW      = 6'd17,
      MN_ADDI    = 6'd18,
      MN_SLTI    = 6'd19,
      MN_SLTIU   = 6'd20,
      MN_XORI    = 6'd21,
      MN_ORI     = 6'd22,
      MN_ANDI    = 6'd23,
      MN_SLLI    = 6'd24,
      MN_SRLI    = 6'd25,
      MN_SRAI    = 6'd26,
      MN_ADD     = 6'd27,
      MN_SUB     = 6'd28,
      MN_SLL     = 6'd29,
      MN_SLT     = 6'd30,
      MN_SLTU    = 6'd31,
      MN_XOR     = 6'd32,
      MN_SRL     = 6'd33,
      MN_SRA     = 6'd34,
      MN_OR      = 6'd35,
      MN_AND     = 6'd36,
      MN_FENCE   = 6'd37,
      MN_FENCE_I = 6'd38,
      MN_ECALL   = 6'd39,
      MN_EBREAK  = 6'd40,
      MN_CSRRW   = 6'd41,
      MN_CSRRS   = 6'd42,
      MN_CSRRC   = 6'd43,
      MN_CSRRWI  = 6'd44,
      MN_CSRRSI  = 6'd45,
      MN_CSRRCI  = 6'd46,
      MN_UNKNOWN = 6'd47
   } mnemonic_type;

   typedef struct packed {
      logic [FenceWidth-1:0]  fence_succ;
      logic [FenceWidth-1:0]  fence_pred;
      logic [CsrWidth-1:0]    csr_number;
      logic signed [31:0]     immediate;
      logic [RegWidth-1:0]    src2_reg;
      logic [RegWidth-1:0]    src1_reg;
      logic [RegWidth-1:0]    dest_reg;
      mnemonic_type           mnemonic_id;
   } result_type;

endpackage
`default_nettype wire

FILE: hdl/rv32i_instruction_decoder.sv
`default_nettype none
// Path: an accepted req beat passes through the input register, decode
//   logic and result register to its rsp beat.
// Throughput: one instruction per cycle; both registers advance whenever
//   the stage ahead is empty or being drained.
// Reset: clears both stage valid flags; no other state.
// ----------------------------------------------------------------------------
// rv32i_instruction_decoder
// Streaming RV32I decoder: mnemonic, register fields, immediate, CSR, fence.
// ----------------------------------------------------------------------------
module rv32i_instruction_decoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // [31:0] instr_word
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [5:0] mnemonic_id, [10:6] dest_reg, [15:11] src1_reg, [20:16] src2_reg,
   // [52:21] immediate, [64:53] csr_number, [68:65] fence_pred,
   // [72:69] fence_succ, [79:73] zero
   output logic [79:0]      rsp_tdata
);

   logic                                  word_valid_ff;
   logic                                  word_valid_in;
   logic [rvid_pkg::InstrWidth-1:0]       word_ff;
   logic                                  rsp_valid_ff;
   logic                                  rsp_valid_in;
   rvid_pkg::result_type                  rsp_ff;
   rvid_pkg::result_type                  decoded;
   logic                                  rsp_advance;
   logic                                  word_advance;

   rvid_decode u_decode (
      .instr_word (word_ff),
      .result     (decoded)
   );

   assign rsp_advance   = !rsp_valid_ff || rsp_tready;
   assign word_advance  = !word_valid_ff || rsp_advance;
   assign req_tready    = word_advance;
   assign word_valid_in = word_advance ? req_tvalid : word_valid_ff;
   assign rsp_valid_in  = rsp_advance ? word_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         word_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         word_valid_ff <= word_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (word_advance && req_tvalid) begin
         word_ff <= req_tdata;
      end
      if (rsp_advance && word_valid_ff) begin
         rsp_ff <= decoded;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{rvid_pkg::RspPad{1'b0}}, rsp_ff};

endmodule
`default_nettype wire

FILE: hdl/rvid_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rvid_decode
// Opcode/funct3/funct7 classification and immediate assembly of one word.
// ----------------------------------------------------------------------------
module rvid_decode (
   input  wire logic [rvid_pkg::InstrWidth-1:0] instr_word,
   output rvid_pkg::result_type                 result
);

   logic [6:0]               opc;
   logic [2:0]               f3;
   logic [6:0]               f7;
   logic [11:0]              hi12;
   logic [31:0]              iimm;
   logic [31:0]              simm;
   logic [31:0]              bimm;
   logic [31:0]              jimm;
   logic [31:0]              uimm;
   rvid_pkg::mnemonic_type   id;
   logic [31:0]              imm;
   logic [11:0]              csr;
   logic                     fence;

   assign opc  = instr_word[6:0];
   assign f3   = instr_word[14:12];
   assign f7   = instr_word[31:25];
   assign hi12 = instr_word[31:20];
   assign iimm = {{20{instr_word[31]}}, instr_word[31:20]};
   assign simm = {{20{instr_word[31]}}, instr_word[31:25], instr_word[11:7]};
   assign bimm = {{19{instr_word[31]}}, instr_word[31], instr_word[7],
                  instr_word[30:25], instr_word[11:8], 1'b0};
   assign jimm = {{11{instr_word[31]}}, instr_word[31], instr_word[19:12],
                  instr_word[20], instr_word[30:21], 1'b0};
   assign uimm = {12'b0, instr_word[31:12]};

   always_comb begin
      id    = rvid_pkg::MN_UNKNOWN;
      imm   = '0;
      csr   = '0;
      fence = 1'b0;
      unique case (opc)
         rvid_pkg::OPC_LUI: begin
            id  = rvid_pkg::MN_LUI;
            imm = uimm;
         end
         rvid_pkg::OPC_AUIPC: begin
            id  = rvid_pkg::MN_AUIPC;
            imm = uimm;
         end
         rvid_pkg::OPC_JAL: begin
            id  = rvid_pkg::MN_JAL;
            imm = jimm;
         end
         rvid_pkg::OPC_JALR: begin
            id  = rvid_pkg::MN_JALR;
            imm = iimm;
         end
         rvid_pkg::OPC_BRANCH: begin
            imm = bimm;
            unique case (f3)
               3'd0:    id = rvid_pkg::MN_BEQ;
               3'd1:    id = rvid_pkg::MN_BNE;
               3'd4:    id = rvid_pkg::MN_BLT;
               3'd5:    id = rvid_pkg::MN_BGE;
               3'd6:    id = rvid_pkg::MN_BLTU;
               3'd7:    id = rvid_pkg::MN_BGEU;
               default: id = rvid_pkg::MN_UNKNOWN;
            endcase
         end
         rvid_pkg::OPC_LOAD: begin
            imm = iimm;
            unique case (f3)
               3'd0:    id = rvid_pkg::MN_LB;
               3'd1:    id = rvid_pkg::MN_LH;
               3'd2:    id = rvid_pkg::MN_LW;
               3'd4:    id = rvid_pkg::MN_LBU;
               3'd5:    id = rvid_pkg::MN_LHU;
               default: id = rvid_pkg::MN_UNKNOWN;
            endcase
         end
         rvid_pkg::OPC_STORE: begin
            imm = simm;
            unique case (f3)
               3'd0:    id = rvid_pkg::MN_SB;
               3'd1:    id = rvid_pkg::MN_SH;
               3'd2:    id = rvid_pkg::MN_SW;
               default: id = rvid_pkg::MN_UNKNOWN;
            endcase
         end
         rvid_pkg::OPC_OPIMM: begin
            imm = iimm;
            unique case (f3)
               3'd0:    id = rvid_pkg::MN_ADDI;
               3'd1:    id = rvid_pkg::MN_SLLI;
               3'd2:    id = rvid_pkg::MN_SLTI;
               3'd3:    id = rvid_pkg::MN_SLTIU;
               3'd4:    id = rvid_pkg::MN_XORI;
               3'd5:    id = (f7 == rvid_pkg::FUNCT7_ZERO) ? rvid_pkg::MN_SRLI
                                                          : rvid_pkg::MN_SRAI;
               3'd6:    id = rvid_pkg::MN_ORI;
               default: id = rvid_pkg::MN_ANDI;
            endcase
         end
         rvid_pkg::OPC_OP: begin
            unique case (f3)
               3'd0:    id = (f7 == rvid_pkg::FUNCT7_ALT) ? rvid_pkg::MN_SUB
                                                         : rvid_pkg::MN_ADD;
               3'd1:    id = rvid_pkg::MN_SLL;
               3'd2:    id = rvid_pkg::MN_SLT;
               3'd3:    id = rvid_pkg::MN_SLTU;
               3'd4:    id = rvid_pkg::MN_XOR;
               3'd5:    id = (f7 == rvid_pkg::FUNCT7_ALT) ? rvid_pkg::MN_SRA
                                                         : rvid_pkg::MN_SRL;
               3'd6:    id = rvid_pkg::MN_OR;
               default: id = rvid_pkg::MN_AND;
            endcase
         end
         rvid_pkg::OPC_MISCMEM: begin
            unique case (f3)
               3'd0: begin
                  id    = rvid_pkg::MN_FENCE;
                  fence = 1'b1;
               end
               3'd1:    id = rvid_pkg::MN_FENCE_I;
               default: id = rvid_pkg::MN_UNKNOWN;
            endcase
         end
         rvid_pkg::OPC_SYSTEM: begin
            csr = hi12;
            unique case (f3)
               3'd0: begin
                  csr = '0;
                  if (hi12 == rvid_pkg::SYS_ECALL) begin
                     id = rvid_pkg::MN_ECALL;
                  end else if (hi12 == rvid_pkg::SYS_EBREAK) begin
                     id = rvid_pkg::MN_EBREAK;
                  end else begin
                     id = rvid_pkg::MN_UNKNOWN;
                  end
               end
               3'd1:    id = rvid_pkg::MN_CSRRW;
               3'd2:    id = rvid_pkg::MN_CSRRS;
               3'd3:    id = rvid_pkg::MN_CSRRC;
               3'd5:    id = rvid_pkg::MN_CSRRWI;
               3'd6:    id = rvid_pkg::MN_CSRRSI;
               3'd7:    id = rvid_pkg::MN_CSRRCI;
               default: id = rvid_pkg::MN_UNKNOWN;
            endcase
         end
         default: id = rvid_pkg::MN_UNKNOWN;
      endcase
   end

   // zero every field but the mnemonic of an unknown word
   always_comb begin
      result             = '0;
      result.mnemonic_id = id;
      if (id != rvid_pkg::MN_UNKNOWN) begin
         result.dest_reg   = instr_word[11:7];
         result.src1_reg   = instr_word[19:15];
         result.src2_reg   = instr_word[24:20];
         result.immediate  = imm;
         result.csr_number = csr;
         result.fence_pred = fence ? instr_word[27:24] : '0;
         result.fence_succ = fence ? instr_word[23:20] : '0;
      end
   end

endmodule
`default_nettype wire

FILE: tb/sv/tb_rv32i_instruction_decoder.sv
// ----------------------------------------------------------------------------
// tb_rv32i_instruction_decoder
// Streams directed and random instruction words through the decoder with
// random idle bursts on both sides. Each word is decoded by a local model
// at its req beat, and each rsp beat is compared field by field against
// the oldest decode still outstanding.
// ----------------------------------------------------------------------------
module tb_rv32i_instruction_decoder;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RANDOM_WORDS = 1600;
   localparam int unsigned QUIET_TAIL   = 150;
   localparam int unsigned STALL_LIMIT  = 1000;
   localparam int unsigned DRAIN_CYCLES = 8;

   localparam logic [2:0] F3_ADD_SUB  = 3'd0;
   localparam logic [2:0] F3_PRIV     = 3'd0;
   localparam logic [2:0] F3_FENCE    = 3'd0;
   localparam logic [2:0] F3_SLL      = 3'd1;
   localparam logic [2:0] F3_FENCE_I  = 3'd1;
   localparam logic [2:0] F3_CSRRW    = 3'd1;
   localparam logic [2:0] F3_WORD     = 3'd2;
   localparam logic [2:0] F3_BR_RSVD  = 3'd2;
   localparam logic [2:0] F3_LD_RSVD  = 3'd3;
   localparam logic [2:0] F3_BLT      = 3'd4;
   localparam logic [2:0] F3_SYS_RSVD = 3'd4;
   localparam logic [2:0] F3_SR       = 3'd5;
   localparam logic [2:0] F3_TOP      = 3'd7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;

   logic [31:0]          pending_words[$];
   rvid_pkg::result_type expected_decodes[$];
   int unsigned          src_gap = 0;
   int unsigned          sink_gap = 0;
   int unsigned          stall_cycles = 0;
   int unsigned          mismatches = 0;
   rvid_pkg::result_type want;
   rvid_pkg::result_type seen;

   rv32i_instruction_decoder DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   function automatic rvid_pkg::result_type decode_word(input logic [31:0] w);
      rvid_pkg::mnemonic_type load_ids [8] = '{
         rvid_pkg::MN_LB, rvid_pkg::MN_LH, rvid_pkg::MN_LW, rvid_pkg::MN_UNKNOWN,
         rvid_pkg::MN_LBU, rvid_pkg::MN_LHU, rvid_pkg::MN_UNKNOWN,
         rvid_pkg::MN_UNKNOWN};
      rvid_pkg::mnemonic_type branch_ids [8] = '{
         rvid_pkg::MN_BEQ, rvid_pkg::MN_BNE, rvid_pkg::MN_UNKNOWN, rvid_pkg::MN_UNKNOWN,
         rvid_pkg::MN_BLT, rvid_pkg::MN_BGE, rvid_pkg::MN_BLTU, rvid_pkg::MN_BGEU};
      rvid_pkg::mnemonic_type store_ids [8] = '{
         rvid_pkg::MN_SB, rvid_pkg::MN_SH, rvid_pkg::MN_SW, rvid_pkg::MN_UNKNOWN,
         rvid_pkg::MN_UNKNOWN, rvid_pkg::MN_UNKNOWN, rvid_pkg::MN_UNKNOWN,
         rvid_pkg::MN_UNKNOWN};
      rvid_pkg::mnemonic_type opimm_ids [8] = '{
         rvid_pkg::MN_ADDI, rvid_pkg::MN_SLLI, rvid_pkg::MN_SLTI, rvid_pkg::MN_SLTIU,
         rvid_pkg::MN_XORI, rvid_pkg::MN_SRLI, rvid_pkg::MN_ORI, rvid_pkg::MN_ANDI};
      rvid_pkg::mnemonic_type op_ids [8] = '{
         rvid_pkg::MN_ADD, rvid_pkg::MN_SLL, rvid_pkg::MN_SLT, rvid_pkg::MN_SLTU,
         rvid_pkg::MN_XOR, rvid_pkg::MN_SRL, rvid_pkg::MN_OR, rvid_pkg::MN_AND};
      rvid_pkg::mnemonic_type csr_ids [8] = '{
         rvid_pkg::MN_UNKNOWN, rvid_pkg::MN_CSRRW, rvid_pkg::MN_CSRRS,
         rvid_pkg::MN_CSRRC, rvid_pkg::MN_UNKNOWN, rvid_pkg::MN_CSRRWI,
         rvid_pkg::MN_CSRRSI, rvid_pkg::MN_CSRRCI};
      rvid_pkg::result_type   r;
      rvid_pkg::mnemonic_type id;
      logic [6:0]   f7;
      logic [2:0]   f3;
      logic [11:0]  hi12;
      logic [31:0]  imm;
      logic [11:0]  csr;
      logic         fence;
      f7    = w[31:25];
      f3    = w[14:12];
      hi12  = w[31:20];
      id    = rvid_pkg::MN_UNKNOWN;
      imm   = '0;
      csr   = '0;
      fence = 1'b0;
      case (w[6:0])
         rvid_pkg::OPC_LUI: begin
            id  = rvid_pkg::MN_LUI;
            imm = {12'h000, w[31:12]};
         end
         rvid_pkg::OPC_AUIPC: begin
            id  = rvid_pkg::MN_AUIPC;
            imm = {12'h000, w[31:12]};
         end
         rvid_pkg::OPC_JAL: begin
            id  = rvid_pkg::MN_JAL;
            imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
         end
         rvid_pkg::OPC_JALR: begin
            id  = rvid_pkg::MN_JALR;
            imm = {{20{w[31]}}, w[31:20]};
         end
         rvid_pkg::OPC_BRANCH: begin
            id  = branch_ids[f3];
            imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
         end
         rvid_pkg::OPC_LOAD: begin
            id  = load_ids[f3];
            imm = {{20{w[31]}}, w[31:20]};
         end
         rvid_pkg::OPC_STORE: begin
            id  = store_ids[f3];
            imm = {{20{w[31]}}, w[31:25], w[11:7]};
         end
         rvid_pkg::OPC_OPIMM: begin
            id  = opimm_ids[f3];
            if (f3 == F3_SR && f7 != rvid_pkg::FUNCT7_ZERO) id = rvid_pkg::MN_SRAI;
            imm = {{20{w[31]}}, w[31:20]};
         end
         rvid_pkg::OPC_OP: begin
            id = op_ids[f3];
            if (f3 == F3_ADD_SUB && f7 == rvid_pkg::FUNCT7_ALT) id = rvid_pkg::MN_SUB;
            if (f3 == F3_SR && f7 == rvid_pkg::FUNCT7_ALT) id = rvid_pkg::MN_SRA;
         end
         rvid_pkg::OPC_MISCMEM: begin
            if (f3 == F3_FENCE) begin
               id    = rvid_pkg::MN_FENCE;
               fence = 1'b1;
            end else if (f3 == F3_FENCE_I) begin
               id = rvid_pkg::MN_FENCE_I;
            end
         end
         rvid_pkg::OPC_SYSTEM: begin
            if (f3 == F3_PRIV) begin
               if (hi12 == rvid_pkg::SYS_ECALL) id = rvid_pkg::MN_ECALL;
               else if (hi12 == rvid_pkg::SYS_EBREAK) id = rvid_pkg::MN_EBREAK;
            end else begin
               id  = csr_ids[f3];
               csr = hi12;
            end
         end
         default: id = rvid_pkg::MN_UNKNOWN;
      endcase
      r = '0;
      r.mnemonic_id = id;
      if (id != rvid_pkg::MN_UNKNOWN) begin
         r.dest_reg   = w[11:7];
         r.src1_reg   = w[19:15];
         r.src2_reg   = w[24:20];
         r.immediate  = imm;
         r.csr_number = csr;
         r.fence_pred = fence ? w[27:24] : 4'h0;
         r.fence_succ = fence ? w[23:20] : 4'h0;
      end
      return r;
   endfunction

   function automatic logic [31:0] pack_word(input logic [6:0] f7, input logic [4:0] rs2,
                                             input logic [4:0] rs1, input logic [2:0] f3,
                                             input logic [4:0] rd, input logic [6:0] opc);
      return {f7, rs2, rs1, f3, rd, opc};
   endfunction

   function automatic logic [31:0] random_word();
      logic [31:0] w;
      int unsigned pick;
      w    = $urandom();
      pick = $urandom_range(0, 15);
      case (pick) inside
         0:       w[6:0] = rvid_pkg::OPC_LUI;
         1:       w[6:0] = rvid_pkg::OPC_AUIPC;
         2:       w[6:0] = rvid_pkg::OPC_JAL;
         3:       w[6:0] = rvid_pkg::OPC_JALR;
         4:       w[6:0] = rvid_pkg::OPC_BRANCH;
         5:       w[6:0] = rvid_pkg::OPC_LOAD;
         6:       w[6:0] = rvid_pkg::OPC_STORE;
         [7:8]:   w[6:0] = rvid_pkg::OPC_OPIMM;
         [9:10]:  w[6:0] = rvid_pkg::OPC_OP;
         11:      w[6:0] = rvid_pkg::OPC_MISCMEM;
         [12:13]: w[6:0] = rvid_pkg::OPC_SYSTEM;
         default: w = w;
      endcase
      if ((w[6:0] == rvid_pkg::OPC_OP || w[6:0] == rvid_pkg::OPC_OPIMM)
          && $urandom_range(0, 2) != 0)
         w[31:25] = $urandom_range(0, 1) ? rvid_pkg::FUNCT7_ALT : rvid_pkg::FUNCT7_ZERO;
      if (w[6:0] == rvid_pkg::OPC_SYSTEM && $urandom_range(0, 2) == 0) begin
         w[14:12] = F3_PRIV;
         w[31:20] = $urandom_range(0, 1) ? rvid_pkg::SYS_EBREAK : rvid_pkg::SYS_ECALL;
      end
      return w;
   endfunction

   task automatic check_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t %s mismatch: expected %h, actual %h", $time, name, exp_val, act_val);
         mismatches++;
      end
   endtask

   // driver: feed words from the pending queue, record the decode per beat
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         src_gap    <= 0;
      end else begin
         if (req_tvalid && req_tready) expected_decodes.push_back(decode_word(req_tdata));
         if (!req_tvalid || req_tready) begin
            if (src_gap != 0) begin
               req_tvalid <= 1'b0;
               src_gap    <= src_gap - 1;
            end else if (pending_words.size() != 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pending_words.pop_front();
               if (pending_words.size() > QUIET_TAIL && $urandom_range(0, 7) == 0)
                  src_gap <= $urandom_range(1, 7);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each rsp beat, then decide on the next stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         sink_gap   <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_decodes.size() == 0) begin
               $display("%0t unexpected rsp beat: expected none, actual %h", $time, rsp_tdata);
               mismatches++;
            end else begin
               want = expected_decodes.pop_front();
               seen = rsp_tdata[72:0];
               check_field("mnemonic_id", want.mnemonic_id, seen.mnemonic_id);
               check_field("dest_reg", want.dest_reg, seen.dest_reg);
               check_field("src1_reg", want.src1_reg, seen.src1_reg);
               check_field("src2_reg", want.src2_reg, seen.src2_reg);
               check_field("immediate", want.immediate, seen.immediate);
               check_field("csr_number", want.csr_number, seen.csr_number);
               check_field("fence_pred", want.fence_pred, seen.fence_pred);
               check_field("fence_succ", want.fence_succ, seen.fence_succ);
               check_field("pad", '0, rsp_tdata[79:73]);
            end
         end
         if (sink_gap != 0) begin
            rsp_tready <= 1'b0;
            sink_gap   <= sink_gap - 1;
         end else if (pending_words.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            sink_gap   <= $urandom_range(0, 6);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      pending_words.push_back(32'h0000_0000);
      pending_words.push_back(32'hFFFF_FFFF);
      pending_words.push_back({20'hFFFFF, 5'd31, rvid_pkg::OPC_LUI});
      pending_words.push_back({20'h00000, 5'd0, rvid_pkg::OPC_AUIPC});
      pending_words.push_back({1'b1, 10'h000, 1'b0, 8'h00, 5'd1, rvid_pkg::OPC_JAL});
      pending_words.push_back({1'b0, 10'h3FF, 1'b1, 8'hFF, 5'd31, rvid_pkg::OPC_JAL});
      pending_words.push_back(pack_word(7'h7F, 5'd31, 5'd31, F3_TOP, 5'd31,
                                        rvid_pkg::OPC_JALR));
      pending_words.push_back(pack_word(7'h7F, 5'd31, 5'd31, F3_BLT, 5'd31,
                                        rvid_pkg::OPC_BRANCH));
      pending_words.push_back(pack_word(7'h3F, 5'd1, 5'd2, F3_BR_RSVD, 5'd3,
                                        rvid_pkg::OPC_BRANCH));
      pending_words.push_back(pack_word(7'h3F, 5'd31, 5'd0, F3_WORD, 5'd1,
                                        rvid_pkg::OPC_LOAD));
      pending_words.push_back(pack_word(7'h00, 5'd4, 5'd5, F3_LD_RSVD, 5'd6,
                                        rvid_pkg::OPC_LOAD));
      pending_words.push_back(pack_word(7'h40, 5'd0, 5'd2, F3_WORD, 5'd0,
                                        rvid_pkg::OPC_STORE));
      pending_words.push_back(pack_word(7'h12, 5'd7, 5'd8, F3_TOP, 5'd9,
                                        rvid_pkg::OPC_STORE));
      pending_words.push_back(pack_word(7'h01, 5'd31, 5'd10, F3_SR, 5'd11,
                                        rvid_pkg::OPC_OPIMM));
      pending_words.push_back(pack_word(rvid_pkg::FUNCT7_ZERO, 5'd1, 5'd12, F3_SR, 5'd13,
                                        rvid_pkg::OPC_OPIMM));
      pending_words.push_back(pack_word(rvid_pkg::FUNCT7_ALT, 5'd14, 5'd15, F3_ADD_SUB,
                                        5'd16, rvid_pkg::OPC_OP));
      pending_words.push_back(pack_word(7'h01, 5'd17, 5'd18, F3_ADD_SUB, 5'd19,
                                        rvid_pkg::OPC_OP));
      pending_words.push_back(pack_word(rvid_pkg::FUNCT7_ALT, 5'd20, 5'd21, F3_SR, 5'd22,
                                        rvid_pkg::OPC_OP));
      pending_words.push_back(pack_word(rvid_pkg::FUNCT7_ALT, 5'd23, 5'd24, F3_SLL, 5'd25,
                                        rvid_pkg::OPC_OP));
      pending_words.push_back({4'hF, 4'hF, 4'hF, 5'd31, F3_FENCE, 5'd31,
                               rvid_pkg::OPC_MISCMEM});
      pending_words.push_back({12'h000, 5'd0, F3_FENCE_I, 5'd0, rvid_pkg::OPC_MISCMEM});
      pending_words.push_back({12'h0FF, 5'd0, F3_TOP, 5'd0, rvid_pkg::OPC_MISCMEM});
      pending_words.push_back({rvid_pkg::SYS_ECALL, 5'd9, F3_PRIV, 5'd3,
                               rvid_pkg::OPC_SYSTEM});
      pending_words.push_back({rvid_pkg::SYS_EBREAK, 5'd0, F3_PRIV, 5'd0,
                               rvid_pkg::OPC_SYSTEM});
      pending_words.push_back({12'h002, 5'd0, F3_PRIV, 5'd0, rvid_pkg::OPC_SYSTEM});
      pending_words.push_back({12'h300, 5'd1, F3_SYS_RSVD, 5'd2, rvid_pkg::OPC_SYSTEM});
      pending_words.push_back({12'hFFF, 5'd31, F3_CSRRW, 5'd31, rvid_pkg::OPC_SYSTEM});
      pending_words.push_back({12'h001, 5'd31, F3_TOP, 5'd1, rvid_pkg::OPC_SYSTEM});
      pending_words.push_back({25'h0, rvid_pkg::OPC_OP} & 32'hFFFF_FFFE);
      repeat (RANDOM_WORDS) pending_words.push_back(random_word());

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || req_tvalid || expected_decodes.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hdl/rvid_pkg.sv
hdl/rvid_decode.sv
hdl/rv32i_instruction_decoder.sv
tb/sv/tb_rv32i_instruction_decoder.sv
